>>> sv/cjd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjd_pkg
// Shared codes, field widths and types for the jagged-diagonal builder.
// ----------------------------------------------------------------------------
package cjd_pkg;

    // field widths
    localparam int ROW_BITS    = 8;
    localparam int COLUMN_BITS = 16;
    localparam int KEY_BITS    = ROW_BITS + COLUMN_BITS;
    localparam int POS_BITS    = 11;
    localparam int RC_BITS     = 9;
    localparam int VAL_BITS    = 16;
    localparam int STAT_BITS   = 3;
    localparam int CMD_BITS    = 3;
    localparam int MAX_ROWS    = 256;

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_LOAD  = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_BUILD = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_PERM  = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_JDIAG = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_COL   = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_SIZE  = 3'd5;

    // status codes
    localparam logic [STAT_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_ROW_RANGE = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_POS_RANGE = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_NOT_BUILT = 3'd4;

    // entry store write from the command side
    typedef struct packed {
        logic                   en;
        logic [ROW_BITS-1:0]    row;
        logic [COLUMN_BITS-1:0] col;
    } t_load_wr;

endpackage

>>> sv/coo_to_jagged_diagonal_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coo_to_jagged_diagonal_builder
// Coordinate entries in, jagged-diagonal pattern (perm, jdiag, col_ind) out.
// ----------------------------------------------------------------------------
// Load, size query, errors and unused commands answer in the cycle after the
// command is taken; perm, jdiag and col_ind reads pass a registered memory read, then the result register.
// Build time grows with R rows in use, L loaded entries, N in range, S key shifts
// of the entry sort, Q row shifts of the row sort, U unique entries and D
// diagonals; the sort loops over the scratch memory dominate. One item in
// flight at a time.
// Reset clears control state only; the memories are not cleared.
module coo_to_jagged_diagonal_builder #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: row_count
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data,
    // command beats
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // row_index[7:0], column_index[23:8], read_position[34:24]
    input  logic [2:0]  i_s_tuser,   // cmd[2:0]
    // result beats
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // read_value[15:0], status[18:16]
);
    import cjd_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int QW = (CW + 1 > POS_BITS) ? CW + 1 : POS_BITS;

    typedef enum logic [2:0] {
        T_IDLE  = 3'b001,
        T_READ  = 3'b010,
        T_BUILD = 3'b100
    } t_tst;

    t_tst                   r_st;
    logic                   r_ovalid;
    logic [VAL_BITS-1:0]    r_value;
    logic [STAT_BITS-1:0]   r_status;
    logic [CMD_BITS-1:0]    r_cmd;
    logic [RC_BITS-1:0]     r_row_count;
    logic [CW-1:0]          r_loaded;
    logic                   r_built;

    logic                   s_acc, cfg_acc;
    logic [CMD_BITS-1:0]    cmd;
    logic [ROW_BITS-1:0]    row;
    logic [COLUMN_BITS-1:0] col;
    logic [POS_BITS-1:0]    pos;
    t_load_wr               load;
    logic                   eng_done;
    logic [CW-1:0]          eng_unique, eng_longest;
    logic [ROW_BITS-1:0]    perm_data;
    logic [CW-1:0]          jdiag_data;
    logic [COLUMN_BITS-1:0] col_data;
    logic [QW-1:0]          q_len;
    logic [STAT_BITS-1:0]   imm_status;
    logic [VAL_BITS-1:0]    imm_value;
    logic                   imm_read;
    logic [31:0]            uniq_ext, jd_ext;

    assign cmd = i_s_tuser;
    assign row = i_s_tdata[7:0];
    assign col = i_s_tdata[23:8];
    assign pos = i_s_tdata[34:24];

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;
    assign o_s_tready  = (r_st == T_IDLE) && (!r_ovalid || i_m_tready);
    assign s_acc       = i_s_tvalid && o_s_tready;

    assign uniq_ext = 32'(eng_unique);
    assign jd_ext   = 32'(jdiag_data);

    // length of the list a read command addresses
    always_comb begin
        unique case (cmd)
            CMD_PERM:  q_len = (eng_unique == '0) ? '0 : QW'(r_row_count);
            CMD_JDIAG: q_len = QW'(eng_longest) + QW'(1);
            default:   q_len = QW'(eng_unique);
        endcase
    end

    // decode of a command that answers at once
    always_comb begin
        imm_status = ST_OK;
        imm_value  = '0;
        imm_read   = 1'b0;
        load       = '{en: 1'b0, row: row, col: col};
        if (cmd == CMD_LOAD) begin
            if (r_loaded == CW'(MAX_ENTRIES)) begin
                imm_status = ST_FULL;
            end else if (RC_BITS'(row) >= r_row_count) begin
                imm_status = ST_ROW_RANGE;
            end else begin
                load.en = s_acc;
            end
        end else if (cmd == CMD_PERM || cmd == CMD_JDIAG || cmd == CMD_COL ||
                     cmd == CMD_SIZE) begin
            if (!r_built) begin
                imm_status = ST_NOT_BUILT;
            end else if (cmd == CMD_SIZE) begin
                imm_value = uniq_ext[VAL_BITS-1:0];
            end else if (QW'(pos) >= q_len) begin
                imm_status = ST_POS_RANGE;
            end else begin
                imm_read = 1'b1;
            end
        end
    end

    cjd_engine #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CW          (CW),
        .AW          (AW)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (s_acc && cmd == CMD_BUILD),
        .i_row_count    (r_row_count),
        .i_loaded_count (r_loaded),
        .i_load         (load),
        .i_q_pos        (pos),
        .o_done         (eng_done),
        .o_unique       (eng_unique),
        .o_longest      (eng_longest),
        .o_perm_data    (perm_data),
        .o_jdiag_data   (jdiag_data),
        .o_col_data     (col_data)
    );

    // command sequencing and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= T_IDLE;
            r_ovalid    <= 1'b0;
            r_row_count <= '0;
            r_loaded    <= '0;
            r_built     <= 1'b0;
        end else begin
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_acc) begin
                r_row_count <= (i_cfg_data > RC_BITS'(MAX_ROWS)) ? RC_BITS'(MAX_ROWS)
                                                                 : i_cfg_data;
                r_built     <= 1'b0;
            end
            unique case (r_st)
                T_IDLE: begin
                    if (s_acc) begin
                        r_cmd <= cmd;
                        if (load.en) begin
                            r_loaded <= r_loaded + CW'(1);
                            r_built  <= 1'b0;
                        end
                        if (cmd == CMD_BUILD) begin
                            r_st <= T_BUILD;
                        end else if (imm_read) begin
                            r_st <= T_READ;
                        end else begin
                            r_ovalid <= 1'b1;
                            r_value  <= imm_value;
                            r_status <= imm_status;
                        end
                    end
                end
                T_READ: begin
                    r_ovalid <= 1'b1;
                    r_status <= ST_OK;
                    if (r_cmd == CMD_PERM) begin
                        r_value <= VAL_BITS'(perm_data);
                    end else if (r_cmd == CMD_JDIAG) begin
                        r_value <= jd_ext[VAL_BITS-1:0];
                    end else begin
                        r_value <= col_data;
                    end
                    r_st <= T_IDLE;
                end
                T_BUILD: begin
                    if (eng_done) begin
                        r_ovalid <= 1'b1;
                        r_value  <= '0;
                        r_status <= ST_OK;
                        r_built  <= 1'b1;
                        r_st     <= T_IDLE;
                    end
                end
                default: begin
                    r_st <= T_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'd0, r_status, r_value};

endmodule

>>> sv/cjd_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjd_engine
// Owns the entry, scratch, row order, row start, diagonal start and column
// memories. A build walks them in phases: clear counts, copy in-range entries,
// insertion sort, de-duplicate with per-row counts, stable row sort by falling
// count, then diagonal fill. When idle the read ports serve queries.
// ----------------------------------------------------------------------------
module cjd_engine #(
    parameter int MAX_ENTRIES = 1024,
    parameter int CW          = 11,
    parameter int AW          = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [cjd_pkg::RC_BITS-1:0]    i_row_count,
    input  logic [CW-1:0]                  i_loaded_count,
    input  cjd_pkg::t_load_wr              i_load,
    input  logic [cjd_pkg::POS_BITS-1:0]   i_q_pos,
    output logic                           o_done,
    output logic [CW-1:0]                  o_unique,
    output logic [CW-1:0]                  o_longest,
    output logic [cjd_pkg::ROW_BITS-1:0]   o_perm_data,
    output logic [CW-1:0]                  o_jdiag_data,
    output logic [cjd_pkg::COLUMN_BITS-1:0] o_col_data
);
    import cjd_pkg::*;

    localparam int XW = (CW > RC_BITS) ? CW : RC_BITS;
    localparam int OW = CW + ROW_BITS;

    typedef enum logic [22:0] {
        E_IDLE = 23'h000001, E_CLR  = 23'h000002, E_CPRD = 23'h000004,
        E_CPWR = 23'h000008, E_S1   = 23'h000010, E_S2   = 23'h000020,
        E_S3   = 23'h000040, E_S4   = 23'h000080, E_D1   = 23'h000100,
        E_D2   = 23'h000200, E_D3   = 23'h000400, E_R1   = 23'h000800,
        E_R2   = 23'h001000, E_R3   = 23'h002000, E_R4   = 23'h004000,
        E_LG   = 23'h008000, E_LG2  = 23'h010000, E_F1   = 23'h020000,
        E_F2   = 23'h040000, E_F3   = 23'h080000, E_F4   = 23'h100000,
        E_FE   = 23'h200000, E_DONE = 23'h400000
    } t_est;

    // memories
    logic [KEY_BITS-1:0]    ent_mem [MAX_ENTRIES];
    logic [KEY_BITS-1:0]    scr_mem [MAX_ENTRIES];
    logic [OW-1:0]          ord_mem [MAX_ROWS];
    logic [AW-1:0]          fst_mem [MAX_ROWS];
    logic [CW-1:0]          dg_mem  [MAX_ENTRIES+1];
    logic [COLUMN_BITS-1:0] cl_mem  [MAX_ENTRIES];

    logic [AW-1:0]          ent_ra;
    logic [KEY_BITS-1:0]    ent_rd;
    logic                   scr_we;
    logic [AW-1:0]          scr_wa, scr_ra;
    logic [KEY_BITS-1:0]    scr_wd, scr_rd;
    logic                   ord_we;
    logic [ROW_BITS-1:0]    ord_wa, ord_ra;
    logic [OW-1:0]          ord_wd, ord_rd;
    logic                   fst_we;
    logic [ROW_BITS-1:0]    fst_wa, fst_ra;
    logic [AW-1:0]          fst_wd, fst_rd;
    logic                   dg_we;
    logic [CW-1:0]          dg_wa, dg_ra, dg_wd, dg_rd;
    logic                   cl_we;
    logic [AW-1:0]          cl_wa, cl_ra;
    logic [COLUMN_BITS-1:0] cl_wd, cl_rd;

    // control registers
    t_est                   r_st, n_st;
    logic [XW-1:0]          r_i, n_i, r_j, n_j;
    logic [CW-1:0]          r_n, n_n, r_m, n_m, r_p, n_p, r_k, n_k, r_cnt, n_cnt;
    logic [CW-1:0]          r_unique, n_unique, r_longest, n_longest;
    logic [KEY_BITS-1:0]    r_v, n_v, r_last, n_last;
    logic [OW-1:0]          r_ov, n_ov;

    logic [XW-1:0]          rc_x, lc_x, im1, jm1, jm2;
    logic [31:0]            q_ext;
    logic [CW-1:0]          src_sum;

    assign rc_x  = XW'(i_row_count);
    assign lc_x  = XW'(i_loaded_count);
    assign im1   = r_i - XW'(1);
    assign jm1   = r_j - XW'(1);
    assign jm2   = r_j - XW'(2);
    assign q_ext = 32'(i_q_pos);
    assign src_sum = CW'(fst_rd) + r_k;

    // memory ports
    always_ff @(posedge i_clk) begin
        if (i_load.en) begin
            ent_mem[i_loaded_count[AW-1:0]] <= {i_load.row, i_load.col};
        end
        ent_rd <= ent_mem[ent_ra];
    end

    always_ff @(posedge i_clk) begin
        if (scr_we) begin
            scr_mem[scr_wa] <= scr_wd;
        end
        scr_rd <= scr_mem[scr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            ord_mem[ord_wa] <= ord_wd;
        end
        ord_rd <= ord_mem[ord_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fst_we) begin
            fst_mem[fst_wa] <= fst_wd;
        end
        fst_rd <= fst_mem[fst_ra];
    end

    always_ff @(posedge i_clk) begin
        if (dg_we) begin
            dg_mem[dg_wa] <= dg_wd;
        end
        dg_rd <= dg_mem[dg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cl_we) begin
            cl_mem[cl_wa] <= cl_wd;
        end
        cl_rd <= cl_mem[cl_ra];
    end

    // build sequencer
    always_comb begin
        n_st = r_st;  n_i = r_i;  n_j = r_j;  n_n = r_n;  n_m = r_m;
        n_p = r_p;  n_k = r_k;  n_cnt = r_cnt;  n_unique = r_unique;
        n_longest = r_longest;  n_v = r_v;  n_last = r_last;  n_ov = r_ov;

        ent_ra = r_i[AW-1:0];
        scr_we = 1'b0;  scr_wa = r_j[AW-1:0];  scr_wd = r_v;  scr_ra = r_i[AW-1:0];
        ord_we = 1'b0;  ord_wa = r_j[ROW_BITS-1:0];  ord_wd = r_ov;
        ord_ra = q_ext[ROW_BITS-1:0];
        fst_we = 1'b0;  fst_wa = r_last[KEY_BITS-1 -: ROW_BITS];
        fst_wd = r_m[AW-1:0];  fst_ra = r_ov[ROW_BITS-1:0];
        dg_we  = 1'b0;  dg_wa = '0;  dg_wd = '0;  dg_ra = q_ext[CW-1:0];
        cl_we  = 1'b0;  cl_wa = r_p[AW-1:0];  cl_wd = scr_rd[COLUMN_BITS-1:0];
        cl_ra  = q_ext[AW-1:0];

        unique case (r_st)
            E_IDLE: begin
                if (i_start) begin
                    dg_we = 1'b1;
                    n_i   = '0;
                    n_n   = '0;
                    n_st  = E_CLR;
                end
            end
            // every row in use starts with a zero count
            E_CLR: begin
                if (r_i >= rc_x) begin
                    n_i  = '0;
                    n_st = E_CPRD;
                end else begin
                    ord_we = 1'b1;
                    ord_wa = r_i[ROW_BITS-1:0];
                    ord_wd = {CW'(0), r_i[ROW_BITS-1:0]};
                    n_i    = r_i + XW'(1);
                end
            end
            // copy entries whose row is still in range
            E_CPRD: begin
                if (r_i >= lc_x) begin
                    n_i  = XW'(1);
                    n_st = E_S1;
                end else begin
                    n_st = E_CPWR;
                end
            end
            E_CPWR: begin
                if (RC_BITS'(ent_rd[KEY_BITS-1 -: ROW_BITS]) < i_row_count) begin
                    scr_we = 1'b1;
                    scr_wa = r_n[AW-1:0];
                    scr_wd = ent_rd;
                    n_n    = r_n + CW'(1);
                end
                n_i  = r_i + XW'(1);
                n_st = E_CPRD;
            end
            // insertion sort of keys
            E_S1: begin
                if (r_i >= XW'(r_n)) begin
                    n_i  = '0;
                    n_m  = '0;
                    n_st = E_D1;
                end else begin
                    n_st = E_S2;
                end
            end
            E_S2: begin
                n_v    = scr_rd;
                n_j    = r_i;
                scr_ra = im1[AW-1:0];
                n_st   = E_S3;
            end
            E_S3: begin
                scr_we = 1'b1;
                if (scr_rd > r_v) begin
                    scr_wd = scr_rd;
                    if (r_j == XW'(1)) begin
                        n_st = E_S4;
                    end else begin
                        scr_ra = jm2[AW-1:0];
                        n_j    = jm1;
                    end
                end else begin
                    n_i  = r_i + XW'(1);
                    n_st = E_S1;
                end
            end
            E_S4: begin
                scr_we = 1'b1;
                scr_wa = '0;
                n_i    = r_i + XW'(1);
                n_st   = E_S1;
            end
            // drop duplicates, count rows, note each row's first entry
            E_D1: begin
                if (r_i >= XW'(r_n)) begin
                    n_st = E_D3;
                end else begin
                    n_st = E_D2;
                end
            end
            E_D2: begin
                if (r_m == '0 || scr_rd != r_last) begin
                    scr_we = 1'b1;
                    scr_wa = r_m[AW-1:0];
                    scr_wd = scr_rd;
                    n_m    = r_m + CW'(1);
                    if (r_m == '0 ||
                        scr_rd[KEY_BITS-1 -: ROW_BITS] != r_last[KEY_BITS-1 -: ROW_BITS]) begin
                        if (r_m != '0) begin
                            ord_we = 1'b1;
                            ord_wa = r_last[KEY_BITS-1 -: ROW_BITS];
                            ord_wd = {r_cnt, r_last[KEY_BITS-1 -: ROW_BITS]};
                        end
                        fst_we = 1'b1;
                        fst_wa = scr_rd[KEY_BITS-1 -: ROW_BITS];
                        n_cnt  = CW'(1);
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                    n_last = scr_rd;
                end
                n_i  = r_i + XW'(1);
                n_st = E_D1;
            end
            E_D3: begin
                n_unique = r_m;
                if (r_m == '0) begin
                    n_longest = '0;
                    n_st      = E_DONE;
                end else begin
                    ord_we = 1'b1;
                    ord_wa = r_last[KEY_BITS-1 -: ROW_BITS];
                    ord_wd = {r_cnt, r_last[KEY_BITS-1 -: ROW_BITS]};
                    n_i    = XW'(1);
                    n_st   = E_R1;
                end
            end
            // stable insertion sort of rows by falling count
            E_R1: begin
                ord_ra = r_i[ROW_BITS-1:0];
                if (r_i >= rc_x) begin
                    n_st = E_LG;
                end else begin
                    n_st = E_R2;
                end
            end
            E_R2: begin
                n_ov   = ord_rd;
                n_j    = r_i;
                ord_ra = im1[ROW_BITS-1:0];
                n_st   = E_R3;
            end
            E_R3: begin
                ord_we = 1'b1;
                if (ord_rd[OW-1 -: CW] < r_ov[OW-1 -: CW]) begin
                    ord_wd = ord_rd;
                    if (r_j == XW'(1)) begin
                        n_st = E_R4;
                    end else begin
                        ord_ra = jm2[ROW_BITS-1:0];
                        n_j    = jm1;
                    end
                end else begin
                    n_i  = r_i + XW'(1);
                    n_st = E_R1;
                end
            end
            E_R4: begin
                ord_we = 1'b1;
                ord_wa = '0;
                n_i    = r_i + XW'(1);
                n_st   = E_R1;
            end
            E_LG: begin
                ord_ra = '0;
                n_st   = E_LG2;
            end
            E_LG2: begin
                n_longest = ord_rd[OW-1 -: CW];
                n_i       = '0;
                n_k       = '0;
                n_p       = '0;
                n_st      = E_F1;
            end
            // diagonal fill: rows in order while their count exceeds k
            E_F1: begin
                ord_ra = r_i[ROW_BITS-1:0];
                if (r_i >= rc_x) begin
                    n_st = E_FE;
                end else begin
                    n_st = E_F2;
                end
            end
            E_F2: begin
                n_ov   = ord_rd;
                fst_ra = ord_rd[ROW_BITS-1:0];
                if (ord_rd[OW-1 -: CW] > r_k) begin
                    n_st = E_F3;
                end else begin
                    n_st = E_FE;
                end
            end
            E_F3: begin
                scr_ra = src_sum[AW-1:0];
                n_st   = E_F4;
            end
            E_F4: begin
                cl_we = 1'b1;
                n_p   = r_p + CW'(1);
                n_i   = r_i + XW'(1);
                n_st  = E_F1;
            end
            E_FE: begin
                dg_we = 1'b1;
                dg_wa = r_k + CW'(1);
                dg_wd = r_p;
                n_k   = r_k + CW'(1);
                n_i   = '0;
                if (r_k + CW'(1) >= r_longest) begin
                    n_st = E_DONE;
                end else begin
                    n_st = E_F1;
                end
            end
            E_DONE: begin
                n_st = E_IDLE;
            end
            default: begin
                n_st = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= E_IDLE;
            r_unique  <= '0;
            r_longest <= '0;
        end else begin
            r_st      <= n_st;
            r_unique  <= n_unique;
            r_longest <= n_longest;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_n    <= n_n;
        r_m    <= n_m;
        r_p    <= n_p;
        r_k    <= n_k;
        r_cnt  <= n_cnt;
        r_v    <= n_v;
        r_last <= n_last;
        r_ov   <= n_ov;
    end

    assign o_done       = (r_st == E_DONE);
    assign o_unique     = r_unique;
    assign o_longest    = r_longest;
    assign o_perm_data  = ord_rd[ROW_BITS-1:0];
    assign o_jdiag_data = dg_rd;
    assign o_col_data   = cl_rd;

endmodule
